### rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int OP_W     = 2;
	localparam int OFF_W    = 12;
	localparam int REQ_W    = 13;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_RESIZE  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADPTR  = 2'd2;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_RD,
		S_EV,
		S_CARVE,
		S_SH_RD,
		S_SH_WR,
		S_TAIL,
		S_HEAD,
		S_DONE
	} state_t;

	// what the current block walk is for
	typedef enum logic [2:0] {
		PH_GRANT,
		PH_REL,
		PH_RSZ_LOC,
		PH_RSZ_GROW,
		PH_RSZ_FREE
	} phase_t;

endpackage

### rtl/first_fit_block_allocator.sv
// A walk reads, then evaluates, each block header it visits, and a split moves table
// entries up one by one; a resize that grows walks three times: locate, search, free.
// One item at a time; the next item is taken while the last result waits.
// Reset: asynchronous; the init state after reset writes the single free block.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// Block table in a one-port-read/one-port-write synchronous memory, walked
// by a sequencer for first-fit search, pointer lookup and split insertion.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
	parameter int ARENA_BYTES  = 4096,
	parameter int HEADER_BYTES = 16,
	parameter int MAX_BLOCKS   = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ffba_pkg::OP_W-1:0]       operation,
	input  logic                            pointer_present,
	input  logic [ffba_pkg::OFF_W-1:0]      payload_offset,
	input  logic [ffba_pkg::REQ_W-1:0]      request_bytes,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ffba_pkg::STATUS_W-1:0]   status,
	output logic                            result_present,
	output logic [ffba_pkg::OFF_W-1:0]      result_offset
);

	localparam int AW = $clog2(ARENA_BYTES + 1);
	localparam int SW = (AW > ffba_pkg::REQ_W) ? AW : ffba_pkg::REQ_W;
	localparam int PW = SW + 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int IW = $clog2(MAX_BLOCKS);

	logic [SW:0] mem [MAX_BLOCKS];
	logic [SW:0] rdata_q;

	ffba_pkg::state_t state_q, state_d;
	ffba_pkg::phase_t phase_q;

	logic [ffba_pkg::OFF_W-1:0]    off_q;
	logic [ffba_pkg::REQ_W-1:0]    want_q;
	logic [CW-1:0]                 i_q, k_q, count_q;
	logic [PW-1:0]                 pos_q;
	logic [IW-1:0]                 idx_q;
	logic [SW-1:0]                 have_q;
	logic                          split_q;
	logic [ffba_pkg::STATUS_W-1:0] st_q;
	logic                          pres_q;
	logic [ffba_pkg::OFF_W-1:0]    res_q;
	logic                          out_valid_q;
	logic [ffba_pkg::STATUS_W-1:0] status_q;
	logic                          result_present_q;
	logic [ffba_pkg::OFF_W-1:0]    result_offset_q;

	logic            rd_free;
	logic [SW-1:0]   rd_size;
	logic [PW-1:0]   pos_hdr;
	logic            is_find, hit, fits, split_ok, walk_end, out_free;
	logic            rd_en, wr_en;
	logic [IW-1:0]   rd_addr, wr_addr;
	logic [SW:0]     wr_data;
	logic [PW-1:0]   want_hdr;

	assign rd_free  = rdata_q[SW];
	assign rd_size  = rdata_q[SW-1:0];
	assign pos_hdr  = pos_q + PW'(HEADER_BYTES);
	assign is_find  = (phase_q == ffba_pkg::PH_GRANT) || (phase_q == ffba_pkg::PH_RSZ_GROW);
	assign fits     = PW'(rd_size) >= PW'(want_q);
	assign hit      = is_find ? (rd_free && fits) : (pos_hdr == PW'(off_q));
	assign want_hdr = PW'(want_q) + PW'(HEADER_BYTES);
	assign split_ok = (PW'(have_q) > want_hdr) && (count_q < CW'(MAX_BLOCKS));
	assign walk_end = i_q >= count_q;
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffba_pkg::S_INIT: state_d = ffba_pkg::S_IDLE;
			ffba_pkg::S_IDLE: begin
				if (in_valid) begin
					if (operation == ffba_pkg::OP_ALLOC || operation == ffba_pkg::OP_RESIZE)
						state_d = ffba_pkg::S_RD;
					else if (operation == ffba_pkg::OP_RELEASE && pointer_present)
						state_d = ffba_pkg::S_RD;
					else
						state_d = ffba_pkg::S_DONE;
				end
			end
			ffba_pkg::S_RD: state_d = walk_end ? ffba_pkg::S_DONE : ffba_pkg::S_EV;
			ffba_pkg::S_EV: begin
				if (!hit) begin
					state_d = ffba_pkg::S_RD;
				end else begin
					unique case (phase_q)
						ffba_pkg::PH_GRANT, ffba_pkg::PH_RSZ_GROW: state_d = ffba_pkg::S_CARVE;
						ffba_pkg::PH_RSZ_LOC:
							state_d = fits ? ffba_pkg::S_CARVE : ffba_pkg::S_RD;
						default: state_d = ffba_pkg::S_DONE;
					endcase
				end
			end
			ffba_pkg::S_CARVE: state_d = split_ok ? ffba_pkg::S_SH_RD : ffba_pkg::S_HEAD;
			ffba_pkg::S_SH_RD:
				state_d = (k_q > CW'(idx_q) + CW'(1)) ? ffba_pkg::S_SH_WR : ffba_pkg::S_TAIL;
			ffba_pkg::S_SH_WR: state_d = ffba_pkg::S_SH_RD;
			ffba_pkg::S_TAIL:  state_d = ffba_pkg::S_HEAD;
			ffba_pkg::S_HEAD:
				state_d = (phase_q == ffba_pkg::PH_RSZ_GROW) ? ffba_pkg::S_RD : ffba_pkg::S_DONE;
			ffba_pkg::S_DONE:  state_d = out_free ? ffba_pkg::S_IDLE : ffba_pkg::S_DONE;
			default: state_d = ffba_pkg::S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = {1'b0, have_q};
		unique case (state_q)
			ffba_pkg::S_INIT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = {1'b1, SW'(ARENA_BYTES - HEADER_BYTES)};
			end
			ffba_pkg::S_RD: rd_en = !walk_end;
			ffba_pkg::S_EV: begin
				if (hit && (phase_q == ffba_pkg::PH_REL || phase_q == ffba_pkg::PH_RSZ_FREE)) begin
					wr_en   = 1'b1;
					wr_addr = i_q[IW-1:0];
					wr_data = {1'b1, rd_size};
				end
			end
			ffba_pkg::S_SH_RD: begin
				rd_en   = 1'b1;
				rd_addr = IW'(k_q - CW'(1));
			end
			ffba_pkg::S_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = k_q[IW-1:0];
				wr_data = rdata_q;
			end
			ffba_pkg::S_TAIL: begin
				wr_en   = 1'b1;
				wr_addr = idx_q + IW'(1);
				wr_data = {1'b1, have_q - SW'(want_q) - SW'(HEADER_BYTES)};
			end
			ffba_pkg::S_HEAD: begin
				wr_en   = 1'b1;
				wr_data = {1'b0, split_q ? SW'(want_q) : have_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffba_pkg::S_INIT;
			phase_q     <= ffba_pkg::PH_GRANT;
			count_q     <= CW'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall && state_q != ffba_pkg::S_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ffba_pkg::S_IDLE: begin
					if (in_valid) begin
						off_q  <= payload_offset;
						want_q <= request_bytes;
						i_q    <= '0;
						pos_q  <= '0;
						st_q   <= ffba_pkg::ST_OK;
						pres_q <= 1'b0;
						res_q  <= '0;
						if (operation == ffba_pkg::OP_RELEASE)
							phase_q <= ffba_pkg::PH_REL;
						else if (operation == ffba_pkg::OP_RESIZE && pointer_present)
							phase_q <= ffba_pkg::PH_RSZ_LOC;
						else
							phase_q <= ffba_pkg::PH_GRANT;
					end
				end
				ffba_pkg::S_RD: begin
					if (walk_end) begin
						unique case (phase_q)
							ffba_pkg::PH_GRANT, ffba_pkg::PH_RSZ_GROW: st_q <= ffba_pkg::ST_NOSPACE;
							ffba_pkg::PH_REL, ffba_pkg::PH_RSZ_LOC:    st_q <= ffba_pkg::ST_BADPTR;
							default: ;
						endcase
					end
				end
				ffba_pkg::S_EV: begin
					if (!hit) begin
						pos_q <= pos_hdr + PW'(rd_size);
						i_q   <= i_q + CW'(1);
					end else begin
						idx_q  <= i_q[IW-1:0];
						have_q <= rd_size;
						if (is_find) begin
							res_q  <= pos_hdr[ffba_pkg::OFF_W-1:0];
							pres_q <= 1'b1;
						end else if (phase_q == ffba_pkg::PH_RSZ_LOC) begin
							if (fits) begin
								res_q  <= off_q;
								pres_q <= 1'b1;
							end else begin
								// grow: first-fit search from the start
								phase_q <= ffba_pkg::PH_RSZ_GROW;
								i_q     <= '0;
								pos_q   <= '0;
							end
						end
					end
				end
				ffba_pkg::S_CARVE: begin
					split_q <= split_ok;
					k_q     <= count_q;
				end
				ffba_pkg::S_SH_WR: k_q <= k_q - CW'(1);
				ffba_pkg::S_HEAD: begin
					if (split_q)
						count_q <= count_q + CW'(1);
					if (phase_q == ffba_pkg::PH_RSZ_GROW) begin
						// block starts never move, so look the old pointer up again
						phase_q <= ffba_pkg::PH_RSZ_FREE;
						i_q     <= '0;
						pos_q   <= '0;
					end
				end
				ffba_pkg::S_DONE: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						status_q         <= st_q;
						result_present_q <= pres_q;
						result_offset_q  <= res_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign in_stall       = state_q != ffba_pkg::S_IDLE;
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign result_present = result_present_q;
	assign result_offset  = result_offset_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(1)) && (count_q <= CW'(MAX_BLOCKS)))
		else $error("block count out of range");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == ffba_pkg::S_HEAD
			&& count_q == $past(count_q) + CW'(1)))
		else $error("block count changed outside a split");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffba_pkg::S_IDLE) |-> !wr_en)
		else $error("table write while idle");

	a_read_then_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffba_pkg::S_RD && !walk_end) |=> (state_q == ffba_pkg::S_EV))
		else $error("walk read not followed by evaluation");

endmodule
